@@ hw/rtl/wstq_pkg.sv @@
// Shared types and constants for the work-stealing task queue block.
// Request and result structs, request classes and status codes.
// No dependencies.
package wstq_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned WID_W   = 2;
  localparam int unsigned THR_W   = 11;
  localparam logic [THR_W-1:0] THR_RESET = 11'd4;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  typedef enum logic [2:0] {
    ST_PUSHED   = 3'd0,
    ST_POPPED   = 3'd1,
    ST_STOLEN   = 3'd2,
    ST_NONE     = 3'd3,
    ST_OVERFLOW = 3'd4
  } wstq_status_e;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_TAKE,
    OP_DROP
  } wstq_op_e;

  typedef struct packed {
    logic              kind;
    logic [WID_W-1:0]  worker_id;
    logic [DATA_W-1:0] payload;
  } wstq_req_t;

  typedef struct packed {
    wstq_status_e      status;
    logic [DATA_W-1:0] task_word;
    logic [WID_W-1:0]  source_worker;
    logic              fast_mode;
  } wstq_rsp_t;

  // Classified request as held in the front-to-back queue
  typedef struct packed {
    wstq_op_e          op;
    logic [WID_W-1:0]  worker_id;
    logic [DATA_W-1:0] payload;
  } wstq_cmd_t;

endpackage

@@ hw/rtl/wstq_front.sv @@
// Front end: takes requests, classifies them and buffers them in a
// two-entry queue towards the back end. Depends on wstq_pkg.
module wstq_front import wstq_pkg::*; #(
  parameter int unsigned NUM_WORKERS  = 4,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  wstq_req_t req_i,
  output logic      busy_o,
  output logic      head_valid_o,
  output wstq_cmd_t head_o,
  input  logic      pop_i
);

  localparam logic [DATA_W-1:0] PMASK = {DATA_W{1'b1}} >> (DATA_W - PAYLOAD_BITS);

  wstq_cmd_t  cmd_q [2];
  wstq_cmd_t  cmd_in;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = cmd_q[rd_ptr_q];
  assign push         = start_i && !busy_o;

  always_comb begin
    cmd_in.worker_id = req_i.worker_id;
    cmd_in.payload   = req_i.payload & PMASK;
    if ({30'b0, req_i.worker_id} >= 32'(NUM_WORKERS)) begin
      cmd_in.op = OP_DROP;
    end else if (req_i.kind == KIND_TAKE) begin
      cmd_in.op = OP_TAKE;
    end else begin
      cmd_in.op = OP_PUSH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

@@ hw/rtl/wstq_back.sv @@
// Back end: ring indices per worker, shared task memory and the sequencer
// that runs push, local pop and the victim scan. Depends on wstq_pkg.
module wstq_back import wstq_pkg::*; #(
  parameter int unsigned NUM_WORKERS  = 4,
  parameter int unsigned QUEUE_DEPTH  = 1024,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [THR_W-1:0] thr_i,
  input  logic             head_valid_i,
  input  wstq_cmd_t        head_i,
  output logic             pop_o,
  output logic             done_o,
  output wstq_rsp_t        rsp_o
);

  localparam int unsigned SPAN      = 2 * QUEUE_DEPTH;
  localparam int unsigned IW        = $clog2(SPAN);
  localparam int unsigned PW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned OW        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WW        = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int unsigned AW        = WW + PW;
  localparam int unsigned MEM_DEPTH = NUM_WORKERS * (1 << PW);
  localparam int unsigned CW        = (OW > THR_W) ? OW : THR_W;

  typedef enum logic [1:0] {
    S_EXEC,
    S_SCAN,
    S_WAIT
  } state_e;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] v);
    return (v == IW'(SPAN - 1)) ? '0 : v + IW'(1);
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] v);
    return (v == '0) ? IW'(SPAN - 1) : v - IW'(1);
  endfunction

  function automatic logic [PW-1:0] slot(input logic [IW-1:0] v);
    return (v >= IW'(QUEUE_DEPTH)) ? PW'(v - IW'(QUEUE_DEPTH)) : PW'(v);
  endfunction

  function automatic logic [OW-1:0] occ(input logic [IW-1:0] b, input logic [IW-1:0] t);
    logic [IW:0] d;
    d = {1'b0, b} - {1'b0, t};
    if (b < t) begin
      d = d + (IW+1)'(SPAN);
    end
    return OW'(d);
  endfunction

  function automatic logic worker_next_wrap(input logic [WW-1:0] w);
    return (w == WW'(NUM_WORKERS - 1));
  endfunction

  state_e          state_q, state_d;
  logic [IW-1:0]   bot_q [NUM_WORKERS];
  logic [IW-1:0]   top_q [NUM_WORKERS];
  logic [WW-1:0]   vic_q, vic_d;
  logic [WW-1:0]   cnt_q, cnt_d;
  logic            done_q, done_d;
  wstq_rsp_t       rsp_q, rsp_d;

  logic [PAYLOAD_BITS-1:0] mem [MEM_DEPTH];
  logic [PAYLOAD_BITS-1:0] rdata_q;
  logic            mem_we, mem_re;
  logic [PW-1:0]   mem_slot;
  logic [AW-1:0]   mem_addr;

  logic [WW-1:0]   rw, vic_nx;
  logic [IW-1:0]   b_rd, t_rd, idx_wval;
  logic            bot_we, top_we;
  logic [OW-1:0]   occ_rd;

  function automatic logic above(input logic [OW-1:0] o, input logic [THR_W-1:0] thr);
    return (CW'(o) > CW'(thr));
  endfunction

  assign rw       = (state_q == S_EXEC) ? WW'(head_i.worker_id) : vic_q;
  assign b_rd     = bot_q[rw];
  assign t_rd     = top_q[rw];
  assign occ_rd   = occ(b_rd, t_rd);
  assign vic_nx   = worker_next_wrap(rw) ? '0 : rw + WW'(1);
  assign mem_addr = {rw, mem_slot};
  assign done_o   = done_q;
  assign rsp_o    = rsp_q;

  always_comb begin
    state_d  = state_q;
    vic_d    = vic_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_slot = slot(b_rd);
    bot_we   = 1'b0;
    top_we   = 1'b0;
    idx_wval = ring_next(b_rd);
    case (state_q)
      S_EXEC: begin
        if (head_valid_i) begin
          pop_o                 = 1'b1;
          rsp_d.status          = ST_NONE;
          rsp_d.task_word       = '0;
          rsp_d.source_worker   = '0;
          rsp_d.fast_mode       = 1'b0;
          case (head_i.op)
            OP_PUSH: begin
              done_d = 1'b1;
              if (occ_rd >= OW'(QUEUE_DEPTH)) begin
                rsp_d.status    = ST_OVERFLOW;
                rsp_d.fast_mode = above(occ_rd, thr_i);
              end else begin
                mem_we          = 1'b1;
                bot_we          = 1'b1;
                rsp_d.status    = ST_PUSHED;
                rsp_d.fast_mode = above(occ_rd + OW'(1), thr_i);
              end
            end
            OP_TAKE: begin
              if (occ_rd != '0) begin
                idx_wval            = ring_prev(b_rd);
                mem_slot            = slot(ring_prev(b_rd));
                bot_we              = 1'b1;
                mem_re              = 1'b1;
                rsp_d.status        = ST_POPPED;
                rsp_d.source_worker = head_i.worker_id;
                rsp_d.fast_mode     = above(occ_rd - OW'(1), thr_i);
                state_d             = S_WAIT;
              end else if (NUM_WORKERS == 1) begin
                done_d = 1'b1;
              end else begin
                vic_d   = vic_nx;
                cnt_d   = WW'(1);
                state_d = S_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (occ_rd >= OW'(2)) begin
          idx_wval            = ring_next(t_rd);
          mem_slot            = slot(t_rd);
          top_we              = 1'b1;
          mem_re              = 1'b1;
          rsp_d.status        = ST_STOLEN;
          rsp_d.source_worker = WID_W'(vic_q);
          state_d             = S_WAIT;
        end else if (cnt_q == WW'(NUM_WORKERS - 1)) begin
          done_d  = 1'b1;
          state_d = S_EXEC;
        end else begin
          vic_d = vic_nx;
          cnt_d = cnt_q + WW'(1);
        end
      end
      S_WAIT: begin
        rsp_d.task_word = DATA_W'(rdata_q);
        done_d          = 1'b1;
        state_d         = S_EXEC;
      end
      default: begin
        state_d = S_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EXEC;
      vic_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
      for (int i = 0; i < NUM_WORKERS; i++) begin
        bot_q[i] <= '0;
        top_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      vic_q   <= vic_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      if (bot_we) begin
        bot_q[rw] <= idx_wval;
      end
      if (top_we) begin
        top_q[rw] <= idx_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= head_i.payload[PAYLOAD_BITS-1:0];
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

endmodule

@@ hw/rtl/work_stealing_task_queues_core.sv @@
// Top level of the work-stealing task queue block: threshold register,
// front end (classify and queue) and back end (deques and task memory).
// Depends on wstq_pkg, wstq_front, wstq_back.
//
//   channel   | signals                      | transfer when
//   ----------+------------------------------+------------------------------
//   request   | start, req_i, busy           | start high and busy low
//   result    | done_o, rsp_o                | every cycle done_o is high
//   config    | cfg_we_i, cfg_wdata_i        | every cycle cfg_we_i is high
//
// A push passes the request queue and the back end's result registers; a local
// pop and a steal also pass the registered task memory read. A steal's scan
// visits k (1 .. NUM_WORKERS-1) victims, a take that finds nothing visits all
// NUM_WORKERS-1 other workers; the back end looks at one worker's indices per
// cycle and waits in S_WAIT on the registered task memory read.
// The two-entry request queue lets requests in while the back end works;
// busy rises only when that queue is full. Results cannot be held off.
// Reset clears indices (all deques empty) and sets the threshold to 4;
// the task memory is not cleared since only written entries are read.
module work_stealing_task_queues_core import wstq_pkg::*; #(
  parameter int unsigned NUM_WORKERS  = 4,
  parameter int unsigned QUEUE_DEPTH  = 1024,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  wstq_req_t        req_i,
  output logic             busy,
  output logic             done_o,
  output wstq_rsp_t        rsp_o,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i
);

  // Fast mode threshold; the user must write it only while the block is idle, the block does not enforce this
  logic [THR_W-1:0] thr_q;

  logic      head_valid;
  wstq_cmd_t head;
  logic      pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Front: request transfer, unknown-worker check, payload masking
  wstq_front #(
    .NUM_WORKERS  (NUM_WORKERS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_i        (req_i),
    .busy_o       (busy),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Back: one request at a time, own bottom first, then round-robin steal
  wstq_back #(
    .NUM_WORKERS  (NUM_WORKERS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thr_i        (thr_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .done_o       (done_o),
    .rsp_o        (rsp_o)
  );

endmodule
